// ===== rtl/rtnm_pkg.sv =====
// Package for the revocation tree node manager.
// Holds node id widths, operation and status codes and the state machine type.
// No dependencies.
`default_nettype none
package rtnm_pkg;
  localparam int unsigned NodeCountDefault = 1024;
  localparam int unsigned IdW = 11;
  localparam int unsigned DepthW = 11;
  localparam int unsigned CountW = 32;

  localparam logic [1:0] KindAlloc = 2'd0;
  localparam logic [1:0] KindRevoke = 2'd1;
  localparam logic [1:0] KindUpdate = 2'd2;
  localparam logic [1:0] KindQuery = 2'd3;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusNoFree = 2'd1;
  localparam logic [1:0] StatusZeroDelta = 2'd2;
  localparam logic [1:0] StatusNoTarget = 2'd3;

  typedef enum logic [4:0] {
    StIdle,
    StAllocRd,
    StAllocWr,
    StAllocNxRd,
    StAllocNxWr,
    StAllocIdRd,
    StAllocId,
    StRevRd,
    StRevTop,
    StWalkRd,
    StWalkChk,
    StSpliceRd,
    StSplice,
    StUpdRd,
    StUpdWr,
    StQryRd,
    StQryOut,
    StOut
  } state_e;
endpackage
`default_nettype wire

// ===== rtl/revocation_tree_node_manager.sv =====
// Top level of the revocation tree node manager.
// Uses rtnm_pkg; holds the link and info memories and the control sequencer.
//
// Usage: an item enters on the input channel (in_valid_i, in_stall_o) with an
// operation kind, a target node, a parent node and a signed delta. One result
// item leaves on the output channel (out_valid_o, out_stall_i) for each item.
// The node memories have one port each with a registered read, and every
// read-modify-write step waits for that read, which sets the latency.
// An item refused with an error status goes straight to the output stage; a
// query reads the node, a count update reads and writes it, an allocate links
// the parent, any successor in the list and the new node, and a revoke walks
// the subtree and the node that ends it, then splices the list. The next item
// is accepted in the cycle after the result enters the output register.
// A result stalled by the receiver holds in the output register while the next
// item is worked on; that item's result then waits, with the input stalled,
// until the register is taken.
// Reset empties the free list, the fresh counter and the root. The memories
// are not cleared: a node not yet allocated must not be named as a target.
`default_nettype none
module revocation_tree_node_manager (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  kind_i,
  input  wire logic [rtnm_pkg::IdW-1:0]    target_node_i,
  input  wire logic [rtnm_pkg::IdW-1:0]    parent_node_i,
  input  wire logic signed [31:0]          delta_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [1:0]                       status_o,
  output logic [rtnm_pkg::IdW-1:0]         new_node_o,
  output logic [rtnm_pkg::IdW-1:0]         q_prev_o,
  output logic [rtnm_pkg::IdW-1:0]         q_next_o,
  output logic [rtnm_pkg::IdW-1:0]         q_depth_o,
  output logic [rtnm_pkg::CountW-1:0]      q_count_o,
  output logic                             q_valid_o
);
  localparam int unsigned NodeCount = rtnm_pkg::NodeCountDefault;
  localparam int unsigned IdW = rtnm_pkg::IdW;
  localparam int unsigned DW = rtnm_pkg::DepthW;
  localparam int unsigned CW = rtnm_pkg::CountW;
  localparam int unsigned AW = $clog2(NodeCount);
  localparam logic [IdW-1:0] None = IdW'(NodeCount);
  localparam int unsigned InfoW = DW + CW + 1;

  logic [2*IdW-1:0] link_mem [NodeCount];
  logic [InfoW-1:0] info_mem [NodeCount];

  logic           lwe, iwe;
  logic [AW-1:0]  laddr, iaddr;
  logic [2*IdW-1:0] lwdata, lrd_q;
  logic [InfoW-1:0] iwdata, ird_q;

  always_ff @(posedge clk_i) begin
    if (lwe) begin
      link_mem[laddr] <= lwdata;
    end
    lrd_q <= link_mem[laddr];
  end

  always_ff @(posedge clk_i) begin
    if (iwe) begin
      info_mem[iaddr] <= iwdata;
    end
    ird_q <= info_mem[iaddr];
  end

  function automatic logic [IdW-1:0] norm(input logic [IdW-1:0] id);
    return (id < None) ? id : None;
  endfunction

  wire [IdW-1:0] rd_prev = norm(lrd_q[2*IdW-1:IdW]);
  wire [IdW-1:0] rd_next = norm(lrd_q[IdW-1:0]);
  wire [DW-1:0]  rd_depth = ird_q[InfoW-1:CW+1];
  wire [CW-1:0]  rd_count = ird_q[CW:1];
  wire           rd_valid = ird_q[0];

  rtnm_pkg::state_e state_q, state_d;
  logic [IdW-1:0] tgt_q, par_q, id_q, nx_q, left_q, cur_q;
  logic [CW-1:0]  delta_q;
  logic [DW-1:0]  top_q;
  logic           from_list_q;
  logic [AW:0]    steps_q;
  logic [IdW-1:0] free_top_q, free_top_d, root_q, root_d;
  logic [AW:0]    fresh_q, fresh_d;

  logic [1:0]     res_status_q;
  logic [IdW-1:0] res_new_q, res_prev_q, res_next_q;
  logic [DW-1:0]  res_depth_q;
  logic [CW-1:0]  res_count_q;
  logic           res_valid_q;

  logic           in_fire, out_free;
  logic [1:0]     in_status;

  assign out_free = !out_valid_o || !out_stall_i;
  assign in_stall_o = state_q != rtnm_pkg::StIdle;
  assign in_fire = in_valid_i && !in_stall_o;

  wire [IdW-1:0] in_tgt = norm(target_node_i);
  wire [IdW-1:0] in_par = norm(parent_node_i);
  wire           have_free = free_top_q != None;
  wire           have_fresh = fresh_q < (AW+1)'(NodeCount);
  wire [IdW-1:0] alloc_nx = (par_q == None) ? root_q : rd_next;
  wire [CW-1:0]  upd_count = rd_count + delta_q;
  wire           walk_last = steps_q == (AW+1)'(NodeCount - 1);

  always_comb begin
    in_status = rtnm_pkg::StatusOk;
    case (kind_i)
      rtnm_pkg::KindAlloc: begin
        if (!have_free && !have_fresh) in_status = rtnm_pkg::StatusNoFree;
      end
      rtnm_pkg::KindUpdate: begin
        if (in_tgt == None) in_status = rtnm_pkg::StatusNoTarget;
        else if (delta_i == '0) in_status = rtnm_pkg::StatusZeroDelta;
      end
      default: begin
        if (in_tgt == None) in_status = rtnm_pkg::StatusNoTarget;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rtnm_pkg::StIdle: begin
        if (in_fire) begin
          if (in_status != rtnm_pkg::StatusOk) begin
            state_d = rtnm_pkg::StOut;
          end else begin
            case (kind_i)
              rtnm_pkg::KindAlloc: state_d = rtnm_pkg::StAllocRd;
              rtnm_pkg::KindRevoke: state_d = rtnm_pkg::StRevRd;
              rtnm_pkg::KindUpdate: state_d = rtnm_pkg::StUpdRd;
              default: state_d = rtnm_pkg::StQryRd;
            endcase
          end
        end
      end
      rtnm_pkg::StAllocRd: state_d = rtnm_pkg::StAllocWr;
      rtnm_pkg::StAllocWr: state_d = (alloc_nx == None) ? rtnm_pkg::StAllocIdRd
                                                        : rtnm_pkg::StAllocNxRd;
      rtnm_pkg::StAllocNxRd: state_d = rtnm_pkg::StAllocNxWr;
      rtnm_pkg::StAllocNxWr: state_d = rtnm_pkg::StAllocIdRd;
      rtnm_pkg::StAllocIdRd: state_d = rtnm_pkg::StAllocId;
      rtnm_pkg::StAllocId: state_d = rtnm_pkg::StOut;
      rtnm_pkg::StRevRd: state_d = rtnm_pkg::StRevTop;
      rtnm_pkg::StRevTop: state_d = (rd_next == None) ? rtnm_pkg::StSpliceRd
                                                      : rtnm_pkg::StWalkRd;
      rtnm_pkg::StWalkRd: state_d = rtnm_pkg::StWalkChk;
      rtnm_pkg::StWalkChk: begin
        if (rd_depth > top_q && rd_next != None && !walk_last) begin
          state_d = rtnm_pkg::StWalkRd;
        end else begin
          state_d = rtnm_pkg::StSpliceRd;
        end
      end
      rtnm_pkg::StSpliceRd: state_d = rtnm_pkg::StSplice;
      rtnm_pkg::StSplice: state_d = rtnm_pkg::StOut;
      rtnm_pkg::StUpdRd: state_d = rtnm_pkg::StUpdWr;
      rtnm_pkg::StUpdWr: state_d = rtnm_pkg::StOut;
      rtnm_pkg::StQryRd: state_d = rtnm_pkg::StQryOut;
      rtnm_pkg::StQryOut: state_d = rtnm_pkg::StOut;
      rtnm_pkg::StOut: begin
        if (out_free) state_d = rtnm_pkg::StIdle;
      end
      default: state_d = rtnm_pkg::StIdle;
    endcase
  end

  // Memory port control and architectural state updates.
  always_comb begin
    lwe = 1'b0; iwe = 1'b0;
    laddr = tgt_q[AW-1:0]; iaddr = tgt_q[AW-1:0];
    lwdata = lrd_q; iwdata = ird_q;
    root_d = root_q; free_top_d = free_top_q; fresh_d = fresh_q;
    case (state_q)
      rtnm_pkg::StAllocRd: begin
        laddr = par_q[AW-1:0]; iaddr = par_q[AW-1:0];
      end
      rtnm_pkg::StAllocWr: begin
        laddr = par_q[AW-1:0];
        if (par_q != None) begin
          lwe = 1'b1;
          lwdata = {lrd_q[2*IdW-1:IdW], id_q};
        end
      end
      rtnm_pkg::StAllocNxRd: begin
        laddr = nx_q[AW-1:0];
      end
      rtnm_pkg::StAllocNxWr: begin
        lwe = 1'b1; laddr = nx_q[AW-1:0];
        lwdata = {id_q, lrd_q[IdW-1:0]};
      end
      rtnm_pkg::StAllocIdRd: begin
        laddr = id_q[AW-1:0];
      end
      rtnm_pkg::StAllocId: begin
        lwe = 1'b1; laddr = id_q[AW-1:0];
        lwdata = {par_q, nx_q};
        iwe = 1'b1; iaddr = id_q[AW-1:0];
        iwdata = {top_q + DW'(1), CW'(1), 1'b1};
        if (par_q == None) root_d = id_q;
        if (from_list_q) free_top_d = rd_next;
        else fresh_d = fresh_q + (AW+1)'(1);
      end
      rtnm_pkg::StRevTop: begin
        iwe = 1'b1;
        iwdata = {rd_depth, rd_count, 1'b0};
        if (rd_count == '0) begin
          lwe = 1'b1;
          lwdata = {lrd_q[2*IdW-1:IdW], free_top_q};
          free_top_d = tgt_q;
        end
      end
      rtnm_pkg::StWalkRd: begin
        laddr = cur_q[AW-1:0]; iaddr = cur_q[AW-1:0];
      end
      rtnm_pkg::StWalkChk: begin
        laddr = cur_q[AW-1:0]; iaddr = cur_q[AW-1:0];
        if (rd_depth > top_q) begin
          iwe = 1'b1;
          iwdata = {rd_depth, rd_count, 1'b0};
          if (rd_count == '0) begin
            lwe = 1'b1;
            lwdata = {lrd_q[2*IdW-1:IdW], free_top_q};
            free_top_d = cur_q;
          end
        end else begin
          lwe = 1'b1;
          lwdata = {left_q, lrd_q[IdW-1:0]};
        end
      end
      rtnm_pkg::StSpliceRd: begin
        laddr = left_q[AW-1:0];
      end
      rtnm_pkg::StSplice: begin
        laddr = left_q[AW-1:0];
        if (left_q == None) begin
          root_d = cur_q;
        end else begin
          lwe = 1'b1;
          lwdata = {lrd_q[2*IdW-1:IdW], cur_q};
        end
      end
      rtnm_pkg::StUpdWr: begin
        iwe = 1'b1;
        iwdata = {rd_depth, upd_count, rd_valid};
        if (upd_count == '0 && !rd_valid) begin
          lwe = 1'b1;
          lwdata = {lrd_q[2*IdW-1:IdW], free_top_q};
          free_top_d = tgt_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      rtnm_pkg::StIdle: begin
        if (in_fire) begin
          tgt_q <= in_tgt; par_q <= in_par;
          delta_q <= delta_i;
          id_q <= have_free ? free_top_q : IdW'(fresh_q);
          from_list_q <= have_free;
          steps_q <= '0;
          res_status_q <= in_status; res_new_q <= None;
          res_prev_q <= None; res_next_q <= None;
          res_depth_q <= '0; res_count_q <= '0; res_valid_q <= 1'b0;
        end
      end
      rtnm_pkg::StAllocWr: begin
        nx_q <= alloc_nx;
        top_q <= (par_q == None) ? DW'(0) : rd_depth;
      end
      rtnm_pkg::StAllocId: begin
        res_new_q <= id_q;
      end
      rtnm_pkg::StRevTop: begin
        top_q <= rd_depth; cur_q <= rd_next; left_q <= rd_prev;
      end
      rtnm_pkg::StWalkChk: begin
        steps_q <= steps_q + (AW+1)'(1);
        if (rd_depth > top_q) cur_q <= rd_next;
      end
      rtnm_pkg::StQryOut: begin
        res_prev_q <= rd_prev; res_next_q <= rd_next;
        res_depth_q <= rd_depth; res_count_q <= rd_count; res_valid_q <= rd_valid;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rtnm_pkg::StIdle;
      free_top_q <= None; root_q <= None; fresh_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      free_top_q <= free_top_d; root_q <= root_d; fresh_q <= fresh_d;
      if (out_free) out_valid_o <= state_q == rtnm_pkg::StOut;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && state_q == rtnm_pkg::StOut) begin
      status_o <= res_status_q; new_node_o <= res_new_q; q_prev_o <= res_prev_q;
      q_next_o <= res_next_q; q_depth_o <= res_depth_q; q_count_o <= res_count_q;
      q_valid_o <= res_valid_q;
    end
  end
endmodule
`default_nettype wire
